/* rtl/gwm_pkg.sv */
// Shared constants, types and functions for the glob wildcard matcher.
`timescale 1ns / 1ps
package gwm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int POS_W       = MAX_PATTERN + 1;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PAT_WORDS   = 4;

   localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
   localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'h3F;

   localparam logic [CSR_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      logic [MAX_PATTERN-1:0][BYTE_W-1:0] pbytes;
      pos_type                            star;
      pos_type                            qmark;
      pos_type                            lmask;
      logic [LEN_W-1:0]                   len;
   } pat_cfg_type;

   typedef struct packed {
      pos_type set;
      logic    seen;
   } fin_type;

   // Spread live bits across runs of stars with one carry chain.
   function automatic pos_type star_close(pos_type set, pos_type star, pos_type lmask);
      pos_type masked;
      pos_type seed;
      pos_type sum;
      masked = set & lmask;
      seed   = masked & star;
      sum    = star + seed;
      return masked | (sum ^ star);
   endfunction

endpackage

/* rtl/gwm_if.sv */
// Valid/ready channel interfaces for subject items and verdicts.
`timescale 1ns / 1ps
interface gwm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] subject_byte;
   logic       byte_present;
   logic       end_of_subject;

   modport source (output valid, output subject_byte, output byte_present,
                   output end_of_subject, input ready);
   modport sink   (input valid, input subject_byte, input byte_present,
                   input end_of_subject, output ready);
endinterface

interface gwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink   (input valid, input matched, output ready);
endinterface

/* rtl/glob_wildcard_matcher.sv */
// Top level of the glob wildcard matcher.
// The verdict passes through the final-set and result registers after its end-of-subject item is taken.
// Throughput: one item per cycle while the verdict path does not stall; each byte advances the set in one step.
// The final star closure sits in its own stage, between the final-set and result registers.
// Reset is synchronous: pattern registers clear, the set returns to position zero.
`timescale 1ns / 1ps
module glob_wildcard_matcher (
   input  logic                           clock,
   input  logic                           reset,
   gwm_req_if.sink                        req_if,
   gwm_rsp_if.source                      rsp_if,
   input  logic                           csr_wr_en,
   input  logic [gwm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gwm_pkg::*;

   pat_cfg_type cfg;
   fin_type     fin;
   logic        accept;
   logic        fin_ready;

   assign req_if.ready = fin_ready;
   assign accept       = req_if.valid && fin_ready;

   gwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gwm_step u_step (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .accept         (accept),
      .subject_byte   (req_if.subject_byte),
      .byte_present   (req_if.byte_present),
      .end_of_subject (req_if.end_of_subject),
      .fin            (fin)
   );

   gwm_verdict u_verdict (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .load        (accept && req_if.end_of_subject),
      .fin         (fin),
      .ready       (fin_ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_matched (rsp_if.matched)
   );

endmodule

/* rtl/gwm_csr.sv */
// Pattern registers and decoded per-position pattern masks.
`timescale 1ns / 1ps
module gwm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [gwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output gwm_pkg::pat_cfg_type               cfg
);
   import gwm_pkg::*;

   logic [PAT_WORDS-1:0][CSR_DATA_W-1:0] pat_ff;
   logic [PAT_WORDS-1:0][CSR_DATA_W-1:0] pat_in;
   logic [LEN_W-1:0]                     len_ff;
   logic [LEN_W-1:0]                     len_in;
   logic [LEN_W-1:0]                     len_sat;

   always_comb begin
      pat_in = pat_ff;
      len_in = len_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PAT_0_7:   pat_in[0] = csr_wdata;
            REG_PAT_8_15:  pat_in[1] = csr_wdata;
            REG_PAT_16_23: pat_in[2] = csr_wdata;
            REG_PAT_24_31: pat_in[3] = csr_wdata;
            REG_PAT_LEN:   len_in    = csr_wdata[LEN_W-1:0];
            default:       len_in    = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff <= '0;
         len_ff <= '0;
      end else begin
         pat_ff <= pat_in;
         len_ff <= len_in;
      end
   end

   assign len_sat = (len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_ff;

   always_comb begin
      cfg       = '0;
      cfg.len   = len_sat;
      cfg.lmask[0] = 1'b1;
      for (int p = 0; p < MAX_PATTERN; p++) begin
         cfg.pbytes[p]  = pat_ff[p >> 3][8*(p & 7) +: BYTE_W];
         cfg.lmask[p+1] = (LEN_W'(p + 1) <= len_sat);
         cfg.star[p]    = (LEN_W'(p) < len_sat) && (cfg.pbytes[p] == STAR_BYTE);
         cfg.qmark[p]   = (LEN_W'(p) < len_sat) && (cfg.pbytes[p] == QMARK_BYTE);
      end
   end

endmodule

/* rtl/gwm_step.sv */
// Live position set: one bit-parallel advance per subject byte.
`timescale 1ns / 1ps
module gwm_step (
   input  logic                       clock,
   input  logic                       reset,
   input  gwm_pkg::pat_cfg_type       cfg,
   input  logic                       accept,
   input  logic [gwm_pkg::BYTE_W-1:0] subject_byte,
   input  logic                       byte_present,
   input  logic                       end_of_subject,
   output gwm_pkg::fin_type           fin
);
   import gwm_pkg::*;

   pos_type live_ff;
   pos_type live_in;
   logic    seen_ff;
   logic    seen_in;
   pos_type closed;
   pos_type nxt;
   pos_type adv;

   always_comb begin
      closed = star_close(live_ff, cfg.star, cfg.lmask);
      nxt    = '0;
      for (int p = 0; p < MAX_PATTERN; p++) begin
         if (closed[p] && cfg.star[p]) begin
            nxt[p] = 1'b1;
         end
         if (closed[p] && !cfg.star[p] && cfg.lmask[p+1] &&
             (cfg.qmark[p] || (cfg.pbytes[p] == subject_byte))) begin
            nxt[p+1] = 1'b1;
         end
      end
      adv = byte_present ? nxt : live_ff;
   end

   always_comb begin
      live_in = live_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (end_of_subject) begin
            live_in = POS_W'(1);
            seen_in = 1'b0;
         end else begin
            live_in = adv;
            seen_in = seen_ff | byte_present;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= POS_W'(1);
         seen_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         seen_ff <= seen_in;
      end
   end

   assign fin.set  = adv;
   assign fin.seen = seen_ff | byte_present;

endmodule

/* rtl/gwm_verdict.sv */
// Final-set stage and verdict output register.
`timescale 1ns / 1ps
module gwm_verdict (
   input  logic                 clock,
   input  logic                 reset,
   input  gwm_pkg::pat_cfg_type cfg,
   input  logic                 load,
   input  gwm_pkg::fin_type     fin,
   output logic                 ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_matched
);
   import gwm_pkg::*;

   fin_type fin_ff;
   logic    fin_vld_ff;
   logic    fin_vld_in;
   logic    out_vld_ff;
   logic    out_vld_in;
   logic    matched_ff;
   logic    fin_move;
   logic    hit;
   pos_type closed;

   assign fin_move = fin_vld_ff && (!out_vld_ff || rsp_ready);
   assign ready    = !fin_vld_ff || fin_move;

   always_comb begin
      closed = star_close(fin_ff.set, cfg.star, cfg.lmask);
      hit    = fin_ff.seen && (cfg.len != '0) && closed[cfg.len];
   end

   always_comb begin
      fin_vld_in = fin_vld_ff;
      if (load) begin
         fin_vld_in = 1'b1;
      end else if (fin_move) begin
         fin_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (fin_move) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         fin_vld_ff <= fin_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fin_ff <= fin;
      end
      if (fin_move) begin
         matched_ff <= hit;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_matched = matched_ff;

endmodule
